[rtl/bfhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfhs_pkg;

  localparam int MAX_LEN       = 5;
  localparam int ALPHABET_SIZE = 36;

  localparam int HASH_W    = 64;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 8;
  localparam int FLEN_W    = 3;
  localparam int FSYM_W    = 6;
  localparam int OUT_CHARS = 5;

  localparam int DIGIT_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam int LETTER_COUNT = 26;
  localparam int LAST_NONZERO = 35;
  localparam int UPPER_BASE   = 36;
  localparam int LOWER_A      = 97;
  localparam int DIGIT_ONE    = 49;
  localparam int DIGIT_ZERO   = 48;
  localparam int UPPER_A      = 65;
  localparam int SHIFT_LO     = 6;
  localparam int SHIFT_HI     = 16;

  typedef struct packed {
    logic                              valid;
    logic [LEN_W-1:0]                  len;
    logic [LEN_W-1:0]                  pos;
    logic [MAX_LEN-1:0][DIGIT_W-1:0]   digits;
  } cand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } bfhs_state_e;

  function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] idx);
    logic [CHAR_W-1:0] i8;
    i8 = CHAR_W'(idx);
    if (32'(idx) < LETTER_COUNT) begin
      return CHAR_W'(LOWER_A) + i8;
    end else if (32'(idx) < LAST_NONZERO) begin
      return CHAR_W'(DIGIT_ONE) + i8 - CHAR_W'(LETTER_COUNT);
    end else if (32'(idx) == LAST_NONZERO) begin
      return CHAR_W'(DIGIT_ZERO);
    end else begin
      return CHAR_W'(UPPER_A) + i8 - CHAR_W'(UPPER_BASE);
    end
  endfunction

  function automatic logic [HASH_W-1:0] sdbm_step(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] c);
    return HASH_W'(c) + (h << SHIFT_LO) + (h << SHIFT_HI) - h;
  endfunction

endpackage

`default_nettype wire

[rtl/bfhs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfhs_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  bfhs_pkg::cand_t                 cand_i,
  input  wire [bfhs_pkg::HASH_W-1:0]      hash_i,
  output bfhs_pkg::cand_t                 cand_o,
  output logic [bfhs_pkg::HASH_W-1:0]     hash_o
);

  logic                          use_digit;
  logic [bfhs_pkg::DIGIT_W-1:0]  digit;
  bfhs_pkg::cand_t               cand_d;
  logic                          valid_q;
  logic [bfhs_pkg::LEN_W-1:0]    len_q;
  logic [bfhs_pkg::LEN_W-1:0]    pos_q;
  logic [bfhs_pkg::MAX_LEN-1:0][bfhs_pkg::DIGIT_W-1:0] digits_q;
  logic [bfhs_pkg::HASH_W-1:0]   hash_d, hash_q;

  always_comb begin
    use_digit = cand_i.pos < cand_i.len;
    digit     = cand_i.digits[cand_i.pos[bfhs_pkg::IDX_W-1:0]];
    hash_d    = use_digit ? bfhs_pkg::sdbm_step(hash_i, bfhs_pkg::symbol_of(digit))
                          : hash_i;
    cand_d     = cand_i;
    cand_d.pos = cand_i.pos + bfhs_pkg::LEN_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cand_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= cand_d.len;
    pos_q    <= cand_d.pos;
    digits_q <= cand_d.digits;
    hash_q   <= hash_d;
  end

  always_comb begin
    cand_o.valid  = valid_q;
    cand_o.len    = len_q;
    cand_o.pos    = pos_q;
    cand_o.digits = digits_q;
  end

  assign hash_o = hash_q;

endmodule

`default_nettype wire

[rtl/bfhs_enum.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfhs_enum (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire [bfhs_pkg::FLEN_W-1:0]     max_length_i,
  input  wire [bfhs_pkg::FSYM_W-1:0]     first_symbol_low_i,
  input  wire [bfhs_pkg::FSYM_W-1:0]     first_symbol_high_i,
  output bfhs_pkg::cand_t                cand_o
);

  logic                                              run_d, run_q;
  logic [bfhs_pkg::LEN_W-1:0]                        len_d, len_q;
  logic [bfhs_pkg::LEN_W-1:0]                        maxl_d, maxl_q;
  logic [bfhs_pkg::DIGIT_W-1:0]                      lo_d, lo_q;
  logic [bfhs_pkg::DIGIT_W-1:0]                      hi_d, hi_q;
  logic [bfhs_pkg::MAX_LEN-1:0][bfhs_pkg::DIGIT_W-1:0] dig_d, dig_q;

  logic [bfhs_pkg::LEN_W-1:0]  maxl_sat;
  logic [bfhs_pkg::FSYM_W-1:0] hi_sat;
  logic                        empty;
  logic                        carry;

  always_comb begin
    if (32'(max_length_i) > bfhs_pkg::MAX_LEN) begin
      maxl_sat = bfhs_pkg::LEN_W'(bfhs_pkg::MAX_LEN);
    end else begin
      maxl_sat = bfhs_pkg::LEN_W'(max_length_i);
    end
    if (32'(first_symbol_high_i) > bfhs_pkg::ALPHABET_SIZE - 1) begin
      hi_sat = bfhs_pkg::FSYM_W'(bfhs_pkg::ALPHABET_SIZE - 1);
    end else begin
      hi_sat = first_symbol_high_i;
    end
    empty = (maxl_sat == '0) || (first_symbol_low_i > hi_sat);
  end

  always_comb begin
    run_d  = run_q;
    len_d  = len_q;
    maxl_d = maxl_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    dig_d  = dig_q;
    carry  = 1'b1;
    if (start_i) begin
      run_d    = !empty;
      len_d    = bfhs_pkg::LEN_W'(1);
      maxl_d   = maxl_sat;
      lo_d     = bfhs_pkg::DIGIT_W'(first_symbol_low_i);
      hi_d     = bfhs_pkg::DIGIT_W'(hi_sat);
      dig_d    = '0;
      dig_d[0] = bfhs_pkg::DIGIT_W'(first_symbol_low_i);
    end else if (run_q) begin
      // advance the odometer, last position fastest
      for (int k = bfhs_pkg::MAX_LEN - 1; k >= 1; k--) begin
        if ((32'(len_q) > k) && carry) begin
          if (dig_q[k] == bfhs_pkg::DIGIT_W'(bfhs_pkg::ALPHABET_SIZE - 1)) begin
            dig_d[k] = '0;
          end else begin
            dig_d[k] = dig_q[k] + bfhs_pkg::DIGIT_W'(1);
            carry    = 1'b0;
          end
        end
      end
      if (carry) begin
        if (dig_q[0] == hi_q) begin
          dig_d[0] = lo_q;
          if (len_q == maxl_q) begin
            run_d = 1'b0;
          end else begin
            len_d = len_q + bfhs_pkg::LEN_W'(1);
          end
        end else begin
          dig_d[0] = dig_q[0] + bfhs_pkg::DIGIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    maxl_q <= maxl_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    dig_q  <= dig_d;
  end

  always_comb begin
    cand_o.valid  = run_q;
    cand_o.len    = len_q;
    cand_o.pos    = '0;
    cand_o.digits = dig_q;
  end

endmodule

`default_nettype wire

[rtl/brute_force_hash_preimage_search_core.sv]
// Brute-force sdbm preimage search.
// Input channel (in_valid_i / in_stall_o): one word per search carries the
// 64-bit target hash, the longest length and the first-symbol index range.
// Output channel (out_valid_o / out_stall_i): one word per search with the
// found flag, the first matching string, its length and a match count.
// A generator walks every candidate in order and feeds one per cycle into a
// chain of MAX_LEN hash cells; cell k folds in the character at position k.
// A search of N candidates, N = (high - low + 1) * (1 + 36 + ... + 36^(L-1)),
// occupies the block from acceptance until the result word; the whole space
// is 62193780 candidates, one per cycle, set by the single candidate that
// enters the cell chain each cycle.
// in_stall_o stays high while a search runs. A finished result sits in the
// output register; while the receiver stalls, the block takes the next word
// and the result of that search waits in the final state until the output
// register frees.
// Reset clears the search control and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module brute_force_hash_preimage_search_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [bfhs_pkg::HASH_W-1:0]      target_hash_i,
  input  wire [bfhs_pkg::FLEN_W-1:0]      max_length_i,
  input  wire [bfhs_pkg::FSYM_W-1:0]      first_symbol_low_i,
  input  wire [bfhs_pkg::FSYM_W-1:0]      first_symbol_high_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            found_o,
  output logic [bfhs_pkg::FLEN_W-1:0]     match_length_o,
  output logic [bfhs_pkg::CHAR_W-1:0]     char_0_o,
  output logic [bfhs_pkg::CHAR_W-1:0]     char_1_o,
  output logic [bfhs_pkg::CHAR_W-1:0]     char_2_o,
  output logic [bfhs_pkg::CHAR_W-1:0]     char_3_o,
  output logic [bfhs_pkg::CHAR_W-1:0]     char_4_o,
  output logic [bfhs_pkg::COUNT_W-1:0]    match_count_o
);

  bfhs_pkg::bfhs_state_e state_d, state_q;

  logic start;
  logic load_out;
  logic pipe_busy;
  logic hit;

  bfhs_pkg::cand_t             cand_w [bfhs_pkg::MAX_LEN+1];
  logic [bfhs_pkg::HASH_W-1:0] hash_w [bfhs_pkg::MAX_LEN+1];

  logic [bfhs_pkg::HASH_W-1:0]  target_q;
  logic                         found_q;
  logic [bfhs_pkg::LEN_W-1:0]   flen_q;
  logic [bfhs_pkg::CHAR_W-1:0]  fm_d [bfhs_pkg::MAX_LEN];
  logic [bfhs_pkg::CHAR_W-1:0]  fm_q [bfhs_pkg::MAX_LEN];
  logic [bfhs_pkg::COUNT_W-1:0] cnt_q;

  logic                         out_valid_q;
  logic                         out_found_q;
  logic [bfhs_pkg::FLEN_W-1:0]  out_len_q;
  logic [bfhs_pkg::CHAR_W-1:0]  out_chars_d [bfhs_pkg::OUT_CHARS];
  logic [bfhs_pkg::CHAR_W-1:0]  out_chars_q [bfhs_pkg::OUT_CHARS];
  logic [bfhs_pkg::COUNT_W-1:0] out_cnt_q;

  // candidate generator and hash chain
  bfhs_enum u_enum (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .max_length_i        (max_length_i),
    .first_symbol_low_i  (first_symbol_low_i),
    .first_symbol_high_i (first_symbol_high_i),
    .cand_o              (cand_w[0])
  );

  assign hash_w[0] = '0;

  for (genvar k = 0; k < bfhs_pkg::MAX_LEN; k++) begin : g_cell
    bfhs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cand_i (cand_w[k]),
      .hash_i (hash_w[k]),
      .cand_o (cand_w[k+1]),
      .hash_o (hash_w[k+1])
    );
  end

  always_comb begin
    pipe_busy = 1'b0;
    for (int k = 0; k <= bfhs_pkg::MAX_LEN; k++) begin
      pipe_busy = pipe_busy | cand_w[k].valid;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfhs_pkg::ST_IDLE:   if (start) state_d = bfhs_pkg::ST_SEARCH;
      bfhs_pkg::ST_SEARCH: if (!pipe_busy) state_d = bfhs_pkg::ST_FINISH;
      bfhs_pkg::ST_FINISH: if (load_out) state_d = bfhs_pkg::ST_IDLE;
      default:             state_d = bfhs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != bfhs_pkg::ST_IDLE);
    start      = in_valid_i && (state_q == bfhs_pkg::ST_IDLE);
    load_out   = (state_q == bfhs_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfhs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // match collection
  assign hit = cand_w[bfhs_pkg::MAX_LEN].valid &&
               (hash_w[bfhs_pkg::MAX_LEN] == target_q);

  always_comb begin
    for (int j = 0; j < bfhs_pkg::MAX_LEN; j++) begin
      if (32'(cand_w[bfhs_pkg::MAX_LEN].len) > j) begin
        fm_d[j] = bfhs_pkg::symbol_of(cand_w[bfhs_pkg::MAX_LEN].digits[j]);
      end else begin
        fm_d[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else if (hit) begin
      found_q <= 1'b1;
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + bfhs_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      target_q <= target_hash_i;
    end
    if (hit && !found_q) begin
      flen_q <= cand_w[bfhs_pkg::MAX_LEN].len;
      fm_q   <= fm_d;
    end
  end

  // output register
  for (genvar j = 0; j < bfhs_pkg::OUT_CHARS; j++) begin : g_out_char
    if (j < bfhs_pkg::MAX_LEN) begin : g_used
      assign out_chars_d[j] = found_q ? fm_q[j] : '0;
    end else begin : g_unused
      assign out_chars_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= found_q;
      out_len_q   <= found_q ? bfhs_pkg::FLEN_W'(flen_q) : '0;
      out_chars_q <= out_chars_d;
      out_cnt_q   <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign match_length_o = out_len_q;
  assign char_0_o       = out_chars_q[0];
  assign char_1_o       = out_chars_q[1];
  assign char_2_o       = out_chars_q[2];
  assign char_3_o       = out_chars_q[3];
  assign char_4_o       = out_chars_q[4];
  assign match_count_o  = out_cnt_q;

  a_gen_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_w[0].valid |-> state_q == bfhs_pkg::ST_SEARCH)
    else $error("candidate generated outside a search");

  a_tail_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_w[bfhs_pkg::MAX_LEN].valid |-> state_q == bfhs_pkg::ST_SEARCH)
    else $error("hash chain active outside a search");

  a_miss_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |->
      (out_len_q == '0 && out_cnt_q == '0 && out_chars_q[0] == '0))
    else $error("result without a match carries data");

  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> out_cnt_q != '0)
    else $error("match reported with zero count");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == bfhs_pkg::ST_FINISH)
    else $error("result word raised outside the final state");

endmodule

`default_nettype wire

[tb/tb_brute_force_hash_preimage_search_core.sv]
`timescale 1ns / 1ps

module tb_brute_force_hash_preimage_search_core;

  localparam int MAX_LEN       = bfhs_pkg::MAX_LEN;
  localparam int ALPHABET_SIZE = bfhs_pkg::ALPHABET_SIZE;
  localparam int HASH_W        = bfhs_pkg::HASH_W;
  localparam int CHAR_W        = bfhs_pkg::CHAR_W;
  localparam int COUNT_W       = bfhs_pkg::COUNT_W;
  localparam int FLEN_W        = bfhs_pkg::FLEN_W;
  localparam int FSYM_W        = bfhs_pkg::FSYM_W;
  localparam int OUT_CHARS     = bfhs_pkg::OUT_CHARS;

  localparam int unsigned RANDOM_ITEMS    = 100;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned PRESSURE_CYCLES = 1500;
  localparam int unsigned DRAIN_CYCLES    = 32;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic                             found;
    logic [FLEN_W-1:0]                match_len;
    logic [OUT_CHARS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]               count;
  } sdbm_result_t;

  typedef struct packed {
    logic [HASH_W-1:0] target;
    logic [FLEN_W-1:0] max_len;
    logic [FSYM_W-1:0] sym_lo;
    logic [FSYM_W-1:0] sym_hi;
    logic              typed;
    sdbm_result_t      want;
  } search_req_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [HASH_W-1:0]   target_hash_i;
  logic [FLEN_W-1:0]   max_length_i;
  logic [FSYM_W-1:0]   first_symbol_low_i;
  logic [FSYM_W-1:0]   first_symbol_high_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                found_o;
  logic [FLEN_W-1:0]   match_length_o;
  logic [CHAR_W-1:0]   char_0_o;
  logic [CHAR_W-1:0]   char_1_o;
  logic [CHAR_W-1:0]   char_2_o;
  logic [CHAR_W-1:0]   char_3_o;
  logic [CHAR_W-1:0]   char_4_o;
  logic [COUNT_W-1:0]  match_count_o;

  sdbm_result_t  pending_results [$];
  search_req_t   directed_rows [$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            burst_on = 1'b0;

  brute_force_hash_preimage_search_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .target_hash_i       (target_hash_i),
    .max_length_i        (max_length_i),
    .first_symbol_low_i  (first_symbol_low_i),
    .first_symbol_high_i (first_symbol_high_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .found_o             (found_o),
    .match_length_o      (match_length_o),
    .char_0_o            (char_0_o),
    .char_1_o            (char_1_o),
    .char_2_o            (char_2_o),
    .char_3_o            (char_3_o),
    .char_4_o            (char_4_o),
    .match_count_o       (match_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CHAR_W-1:0] char_of(input int unsigned idx);
    if (idx <= 25) begin
      return CHAR_W'(8'd97 + idx);
    end else if (idx <= 34) begin
      return CHAR_W'(8'd49 + idx - 26);
    end else if (idx == 35) begin
      return 8'd48;
    end else begin
      return CHAR_W'(8'd65 + idx - 36);
    end
  endfunction

  function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                   input logic [CHAR_W-1:0] c);
    return h * 64'd65599 + HASH_W'(c);
  endfunction

  // Walk the whole candidate space in search order.
  function automatic sdbm_result_t search_space(input search_req_t req);
    sdbm_result_t      res;
    int unsigned       top_len, lo, hi, len, m, j;
    int                k;
    bit                wrapped;
    logic [FSYM_W-1:0] digit [MAX_LEN];
    logic [HASH_W-1:0] prefix [MAX_LEN];
    res = '0;
    top_len = (req.max_len > MAX_LEN) ? MAX_LEN : 32'(req.max_len);
    lo = 32'(req.sym_lo);
    hi = (req.sym_hi > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : 32'(req.sym_hi);
    for (len = 1; len <= top_len; len++) begin
      for (m = lo; m <= hi; m++) begin
        digit[0] = FSYM_W'(m);
        prefix[0] = fold_char('0, char_of(m));
        for (j = 1; j < len; j++) begin
          digit[j] = '0;
          prefix[j] = fold_char(prefix[j-1], char_of(0));
        end
        wrapped = 1'b0;
        while (!wrapped) begin
          if (prefix[len-1] == req.target) begin
            if (!res.found) begin
              res.found = 1'b1;
              res.match_len = FLEN_W'(len);
              for (j = 0; j < len; j++) res.chars[j] = char_of(32'(digit[j]));
            end
            if (res.count != 8'hff) res.count = res.count + 1'b1;
          end
          k = len - 1;
          while (k >= 1 && digit[k] == ALPHABET_SIZE - 1) begin
            digit[k] = '0;
            k--;
          end
          if (k < 1) begin
            wrapped = 1'b1;
          end else begin
            digit[k] = digit[k] + 1'b1;
            for (j = k; j < len; j++) begin
              prefix[j] = fold_char(prefix[j-1], char_of(32'(digit[j])));
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic search_req_t pick_request(input int unsigned n);
    search_req_t       req;
    int unsigned       kind, top_len, hi_eff, cand_len, p;
    logic [HASH_W-1:0] h;
    req = '0;
    kind = $urandom_range(0, 99);
    if (n >= 10 && n < 20) begin
      req.max_len = 3'd1;
      req.sym_lo = FSYM_W'($urandom_range(0, 3));
      req.sym_hi = FSYM_W'($urandom_range(32, 63));
    end else if (n % 20 == 5) begin
      req.max_len = 3'd4;
      req.sym_lo = FSYM_W'($urandom_range(0, ALPHABET_SIZE - 1));
      req.sym_hi = req.sym_lo;
    end else if (kind < 10) begin
      req.max_len = FLEN_W'($urandom_range(0, 7));
      req.sym_lo = FSYM_W'($urandom_range(36, 63));
      req.sym_hi = FSYM_W'($urandom_range(0, 63));
    end else if (kind < 45) begin
      req.max_len = 3'd3;
      req.sym_lo = FSYM_W'($urandom_range(0, ALPHABET_SIZE - 1));
      req.sym_hi = FSYM_W'(32'(req.sym_lo) + $urandom_range(0, 3));
    end else begin
      req.max_len = FLEN_W'($urandom_range(1, 2));
      req.sym_lo = FSYM_W'($urandom_range(0, 63));
      req.sym_hi = FSYM_W'($urandom_range(0, 63));
    end
    req.target = {$urandom, $urandom};
    top_len = (req.max_len > MAX_LEN) ? MAX_LEN : 32'(req.max_len);
    hi_eff = (req.sym_hi > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : 32'(req.sym_hi);
    // aim at a string inside the searched space most of the time
    if (top_len != 0 && req.sym_lo <= hi_eff && $urandom_range(0, 9) < 7) begin
      cand_len = $urandom_range(1, top_len);
      h = fold_char('0, char_of($urandom_range(32'(req.sym_lo), hi_eff)));
      for (p = 1; p < cand_len; p++) begin
        h = fold_char(h, char_of($urandom_range(0, ALPHABET_SIZE - 1)));
      end
      req.target = h;
    end
    return req;
  endfunction

  task automatic add_row(input logic [HASH_W-1:0] target, input logic [FLEN_W-1:0] max_len,
                         input logic [FSYM_W-1:0] lo, input logic [FSYM_W-1:0] hi,
                         input logic typed, input logic found, input logic [FLEN_W-1:0] len,
                         input logic [OUT_CHARS*CHAR_W-1:0] chars,
                         input logic [COUNT_W-1:0] count);
    search_req_t row;
    row.target = target;
    row.max_len = max_len;
    row.sym_lo = lo;
    row.sym_hi = hi;
    row.typed = typed;
    row.want.found = found;
    row.want.match_len = len;
    row.want.chars = chars;
    row.want.count = count;
    directed_rows.push_back(row);
  endtask

  task automatic offer(input search_req_t req);
    sdbm_result_t want;
    int unsigned  g;
    want = req.typed ? req.want : search_space(req);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    target_hash_i = req.target;
    max_length_i = req.max_len;
    first_symbol_low_i = req.sym_lo;
    first_symbol_high_i = req.sym_hi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(want);
    g = burst_on ? 0 : idle_len();
    if (g != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  initial begin : request_side
    in_valid_i = 1'b0;
    target_hash_i = '0;
    max_length_i = '0;
    first_symbol_low_i = '0;
    first_symbol_high_i = '0;
    rst_ni = 1'b0;

    add_row(64'd97,           3'd1, 6'd0,  6'd35, 1'b1, 1'b1, 3'd1, 40'h61,   8'd1);
    add_row(64'd48,           3'd1, 6'd35, 6'd63, 1'b1, 1'b1, 3'd1, 40'h30,   8'd1);
    add_row(64'd0,            3'd0, 6'd0,  6'd35, 1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row({HASH_W{1'b1}},   3'd7, 6'd36, 6'd63, 1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd97,           3'd6, 6'd63, 6'd0,  1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd97,           3'd5, 6'd1,  6'd0,  1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd97,           3'd1, 6'd1,  6'd35, 1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd6363201,      3'd2, 6'd0,  6'd0,  1'b1, 1'b1, 3'd2, 40'h6261, 8'd1);
    add_row(64'd8003200,      3'd2, 6'd25, 6'd25, 1'b1, 1'b1, 3'd2, 40'h7a7a, 8'd1);
    add_row(64'd3148849,      3'd2, 6'd35, 6'd63, 1'b1, 1'b1, 3'd2, 40'h6130, 8'd1);
    add_row(64'd0,            3'd2, 6'd0,  6'd35, 1'b1, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd57,           3'd1, 6'd34, 6'd34, 1'b1, 1'b1, 3'd1, 40'h39,   8'd1);
    add_row(64'd49,           3'd2, 6'd26, 6'd30, 1'b1, 1'b1, 3'd1, 40'h31,   8'd1);
    add_row(64'd417419622498, 3'd3, 6'd0,  6'd0,  1'b0, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row({HASH_W{1'b1}},   3'd3, 6'd0,  6'd1,  1'b0, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd6363151,      3'd2, 6'd0,  6'd35, 1'b0, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'd122,          3'd3, 6'd25, 6'd25, 1'b0, 1'b0, 3'd0, 40'h0,    8'd0);
    add_row(64'h8000_0000_0000_0001, 3'd4, 6'd35, 6'd35, 1'b0, 1'b0, 3'd0, 40'h0, 8'd0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) offer(directed_rows[i]);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      burst_on = (n >= 10 && n < 20);
      offer(pick_request(n));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_brute_force_hash_preimage_search_core: clean");
    end else begin
      $display("tb_brute_force_hash_preimage_search_core: errors");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned hold_left;
    int unsigned quiet_left;
    bit          pressure_done;
    hold_left = 0;
    quiet_left = 0;
    pressure_done = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // hold off while the sender streams short searches
      if (burst_on && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES;
        quiet_left = 0;
      end
      if (hold_left == 0 && quiet_left == 0) begin
        if ($urandom_range(0, 9) < 4) quiet_left = $urandom_range(5, 100);
        else hold_left = idle_len();
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = 1'b0;
        if (quiet_left != 0) quiet_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sdbm_result_t want;
    sdbm_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.found = found_o;
      got.match_len = match_length_o;
      got.chars = {char_4_o, char_3_o, char_2_o, char_1_o, char_0_o};
      got.count = match_count_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result word: found=%0d len=%0d chars=%h count=%0d",
                   got.found, got.match_len, got.chars, got.count);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.match_len !== want.match_len ||
            got.chars !== want.chars || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result mismatch: exp found=%0d len=%0d chars=%h count=%0d",
                     want.found, want.match_len, want.chars, want.count);
            $display("                 got found=%0d len=%0d chars=%h count=%0d",
                     got.found, got.match_len, got.chars, got.count);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_brute_force_hash_preimage_search_core: errors");
      $finish;
    end
  end

endmodule
